// ===== sv/lfr_pkg.sv =====
// lfr_pkg: shared widths, operation codes and beat types of the lru frame replacer
// used by lfr_cell and lru_frame_replacer; no dependencies

package lfr_pkg;

  // field widths
  localparam int FUNC_W    = 2;
  localparam int FRAME_W   = 6;
  localparam int COUNT_W   = 7;
  localparam int CAP_W     = 7;

  // default list depth and capacity after reset
  localparam int MAX_FRAMES_DEF = 64;
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  // operation codes
  localparam logic [FUNC_W-1:0] FUNC_VICTIM = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_PIN    = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_UNPIN  = 2'd2;

  // input beat
  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [FRAME_W-1:0] frame;
  } lfr_in_t;

  // result beat
  typedef struct packed {
    logic               victim_valid;
    logic [FRAME_W-1:0] victim_frame;
    logic [COUNT_W-1:0] count;
  } lfr_out_t;

  // broadcast control from the top level to every list cell
  typedef struct packed {
    logic               ins;        // append frame at first empty cell
    logic               pin;        // remove the cell holding frame
    logic               shift_all;  // drop the oldest entry
    logic [FRAME_W-1:0] frame;
  } lfr_ctl_t;

endpackage

// ===== sv/lfr_cell.sv =====
// lfr_cell: one slot of the ordered frame list, shifts toward the oldest end
// depends on lfr_pkg

module lfr_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  lfr_pkg::lfr_ctl_t           ctl,
  input  logic                        prev_valid_i,  // older neighbor holds an entry
  input  logic                        shift_i,       // older neighbor shifts
  input  logic                        up_valid_i,    // newer neighbor view
  input  logic [lfr_pkg::FRAME_W-1:0] up_frame_i,
  output logic                        valid_o,
  output logic                        hit_o,
  output logic                        shift_o,
  output logic                        view_valid_o,
  output logic [lfr_pkg::FRAME_W-1:0] view_frame_o
);

  logic                        valid_r, valid_nxt;
  logic [lfr_pkg::FRAME_W-1:0] frame_r, frame_nxt;
  logic                        load_new;

  // local match and shift chain
  assign hit_o   = valid_r && (frame_r == ctl.frame);
  assign shift_o = shift_i | (ctl.pin & hit_o);

  // view after a possible append, handed to the older neighbor
  assign load_new     = ctl.ins && !valid_r && prev_valid_i;
  assign view_valid_o = valid_r | load_new;
  assign view_frame_o = load_new ? ctl.frame : frame_r;
  assign valid_o      = valid_r;

  // next slot content
  always_comb begin
    if (shift_o) begin
      valid_nxt = up_valid_i;
      frame_nxt = up_frame_i;
    end else begin
      valid_nxt = view_valid_o;
      frame_nxt = view_frame_o;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    frame_r <= frame_nxt;
  end

endmodule

// ===== sv/lru_frame_replacer.sv =====
// lru_frame_replacer: least-recently-unpinned frame list as a row of shifting cells
// the result beat is registered at the edge that accepts its input beat
// throughput: one beat per cycle while the result beat is not stalled; the whole cell row updates at the same edge
// a stalled result beat holds off the input until it is taken
// reset: list emptied, count zero, capacity 64, no result pending, no clearing pass
// depends on lfr_pkg and lfr_cell

module lru_frame_replacer #(
  parameter int MAX_FRAMES = lfr_pkg::MAX_FRAMES_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // input channel
  input  logic                      in_valid,
  output logic                      in_stall,
  input  lfr_pkg::lfr_in_t          in_data,
  // result channel
  output logic                      out_valid,
  input  logic                      out_stall,
  output lfr_pkg::lfr_out_t         out_data,
  // capacity register write
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [lfr_pkg::CAP_W-1:0] cfg_capacity
);

  localparam int CNT_W = $clog2(MAX_FRAMES + 1);
  localparam int CMP_W = ((CNT_W > lfr_pkg::CAP_W) ? CNT_W : lfr_pkg::CAP_W) + 1;

  logic                        fire;
  logic [lfr_pkg::CAP_W-1:0]   capacity_r;
  logic [CNT_W-1:0]            count_r, count_nxt;
  logic                        out_valid_r;
  lfr_pkg::lfr_out_t           out_data_r, out_data_nxt;
  lfr_pkg::lfr_ctl_t           ctl;

  logic [MAX_FRAMES-1:0]       cell_valid;
  logic [MAX_FRAMES-1:0]       cell_hit;
  logic [MAX_FRAMES:0]         shift_chain;
  logic [MAX_FRAMES:0]         view_valid;
  logic [lfr_pkg::FRAME_W-1:0] view_frame [MAX_FRAMES+1];

  logic                        frame_ok, member, not_full, non_empty;
  logic                        is_victim, is_pin, is_unpin;
  logic                        do_victim, do_pin, do_ins, overflow;
  logic [CMP_W-1:0]            count_plus, cap_ext, count_ext;

  // handshakes
  assign fire      = in_valid && !in_stall;
  assign in_stall  = out_valid_r && out_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // decode
  assign frame_ok  = ({{(32-lfr_pkg::FRAME_W){1'b0}}, in_data.frame} < 32'(MAX_FRAMES));
  assign member    = |cell_hit;
  assign not_full  = (count_r < CNT_W'(MAX_FRAMES));
  assign non_empty = (count_r != '0);
  assign is_victim = (in_data.func == lfr_pkg::FUNC_VICTIM);
  assign is_pin    = (in_data.func == lfr_pkg::FUNC_PIN);
  assign is_unpin  = (in_data.func == lfr_pkg::FUNC_UNPIN);

  assign do_victim = fire && is_victim && non_empty;
  assign do_pin    = fire && is_pin && frame_ok && member;
  assign do_ins    = fire && is_unpin && frame_ok && !member && not_full;

  // overflow check after an append
  assign count_ext  = CMP_W'(count_r);
  assign count_plus = count_ext + CMP_W'(1);
  assign cap_ext    = CMP_W'(capacity_r);
  assign overflow   = (count_plus > cap_ext);

  // control broadcast to the cell row
  always_comb begin
    ctl.ins       = do_ins;
    ctl.pin       = do_pin;
    ctl.shift_all = do_victim || (do_ins && overflow);
    ctl.frame     = in_data.frame;
  end

  // cell row, slot 0 holds the oldest frame
  assign shift_chain[0]         = ctl.shift_all;
  assign view_valid[MAX_FRAMES] = 1'b0;
  assign view_frame[MAX_FRAMES] = '0;

  for (genvar i = 0; i < MAX_FRAMES; i++) begin : g_cell
    logic prev_valid;
    if (i == 0) begin : g_first
      assign prev_valid = 1'b1;
    end else begin : g_rest
      assign prev_valid = cell_valid[i-1];
    end

    lfr_cell u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .ctl          (ctl),
      .prev_valid_i (prev_valid),
      .shift_i      (shift_chain[i]),
      .up_valid_i   (view_valid[i+1]),
      .up_frame_i   (view_frame[i+1]),
      .valid_o      (cell_valid[i]),
      .hit_o        (cell_hit[i]),
      .shift_o      (shift_chain[i+1]),
      .view_valid_o (view_valid[i]),
      .view_frame_o (view_frame[i])
    );
  end

  // count update
  always_comb begin
    count_nxt = count_r;
    if (do_victim || do_pin) begin
      count_nxt = count_r - CNT_W'(1);
    end else if (do_ins && !overflow) begin
      count_nxt = count_r + CNT_W'(1);
    end
  end

  // result beat
  always_comb begin
    logic [CMP_W-1:0] cnt_wide;
    cnt_wide = CMP_W'(count_nxt);
    out_data_nxt.victim_valid = do_victim;
    out_data_nxt.victim_frame = do_victim ? view_frame[0] : '0;
    out_data_nxt.count        = cnt_wide[lfr_pkg::COUNT_W-1:0];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r  <= lfr_pkg::CAP_RESET;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        capacity_r <= cfg_capacity;
      end
      count_r <= count_nxt;
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

// ===== test/lru_frame_replacer_checker.sv =====
// lru_frame_replacer_checker: tracks the frame list, predicts each result beat and compares
// depends on lfr_pkg; instantiated by lru_frame_replacer_tb beside the block

module lru_frame_replacer_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  lfr_pkg::lfr_in_t          in_data,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  lfr_pkg::lfr_out_t         out_data,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [lfr_pkg::CAP_W-1:0] cfg_capacity,
  output int                        errors,
  output int                        pending
);

  localparam int CNT_W = lfr_pkg::COUNT_W;

  // predicted list, slot 0 is the oldest frame
  logic [lfr_pkg::FRAME_W-1:0]        lru_order[$];
  logic [lfr_pkg::MAX_FRAMES_DEF-1:0] listed_mark;
  logic [lfr_pkg::CAP_W-1:0]          cap_limit;
  lfr_pkg::lfr_out_t                  due_results[$];

  initial begin
    errors  = 0;
    pending = 0;
  end

  // apply one request to the predicted list and return its result beat
  function automatic lfr_pkg::lfr_out_t lru_apply(lfr_pkg::lfr_in_t beat);
    lfr_pkg::lfr_out_t           res;
    logic [lfr_pkg::FRAME_W-1:0] oldest;
    res = '0;
    case (beat.func)
      lfr_pkg::FUNC_VICTIM: begin
        if (lru_order.size() > 0) begin
          oldest = lru_order.pop_front();
          listed_mark[oldest] = 1'b0;
          res.victim_valid = 1'b1;
          res.victim_frame = oldest;
        end
      end
      lfr_pkg::FUNC_PIN: begin
        // remove a listed frame from wherever it sits
        if (listed_mark[beat.frame]) begin
          listed_mark[beat.frame] = 1'b0;
          for (int i = 0; i < lru_order.size(); i++) begin
            if (lru_order[i] == beat.frame) begin
              lru_order.delete(i);
              break;
            end
          end
        end
      end
      lfr_pkg::FUNC_UNPIN: begin
        // new frames go to the recent end, overflow drops one oldest entry
        if (!listed_mark[beat.frame] && lru_order.size() < lfr_pkg::MAX_FRAMES_DEF) begin
          listed_mark[beat.frame] = 1'b1;
          lru_order.push_back(beat.frame);
          if (lru_order.size() > cap_limit) begin
            oldest = lru_order.pop_front();
            listed_mark[oldest] = 1'b0;
          end
        end
      end
      default: ;
    endcase
    res.count = CNT_W'(lru_order.size());
    return res;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  // watch all three channels at the rising edge
  always @(posedge clk) begin
    lfr_pkg::lfr_out_t want;
    if (!rst_n) begin
      lru_order.delete();
      due_results.delete();
      listed_mark = '0;
      cap_limit   = lfr_pkg::CAP_RESET;
    end else begin
      // compare before queuing, a result never leaves in its own input cycle
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          errors++;
          $display("%0t: result beat %h with nothing expected", $time, out_data);
        end else begin
          want = due_results.pop_front();
          check_field("victim_valid", 8'(want.victim_valid), 8'(out_data.victim_valid));
          check_field("victim_frame", 8'(want.victim_frame), 8'(out_data.victim_frame));
          check_field("count", 8'(want.count), 8'(out_data.count));
        end
      end
      if (in_valid && !in_stall)
        due_results.push_back(lru_apply(in_data));
      if (cfg_valid && cfg_ready)
        cap_limit = cfg_capacity;
    end
    pending = due_results.size();
  end

endmodule

// ===== test/lru_frame_replacer_tb.sv =====
// lru_frame_replacer_tb: drives request beats and capacity writes into the frame replacer
// depends on lfr_pkg, lru_frame_replacer and lru_frame_replacer_checker

module lru_frame_replacer_tb;

  localparam logic [lfr_pkg::FUNC_W-1:0] FUNC_NONE = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 200;
  localparam int N_PHASES    = 8;

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_stall;
  lfr_pkg::lfr_in_t          in_data;
  logic                      out_valid;
  logic                      out_stall;
  lfr_pkg::lfr_out_t         out_data;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [lfr_pkg::CAP_W-1:0] cfg_capacity;
  int                        errors;
  int                        pending;
  int                        send_idle_pct;
  int                        recv_stall_pct;
  int                        cycle_count;

  lru_frame_replacer DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_capacity (cfg_capacity)
  );

  lru_frame_replacer_checker checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_capacity (cfg_capacity),
    .errors       (errors),
    .pending      (pending)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // run guard
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // receiver back-pressure
  always @(negedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < recv_stall_pct);
  end

  // one request beat, with random idle cycles ahead of it
  task automatic send_beat(input lfr_pkg::lfr_in_t beat);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // drop valid and wait until every result beat is back
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_capacity(input logic [lfr_pkg::CAP_W-1:0] value);
    @(negedge clk);
    cfg_valid    <= 1'b1;
    cfg_capacity <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
      default: begin send_idle_pct = 36; recv_stall_pct = 36; end
    endcase
  endtask

  // random request; narrow frames hit the same few list entries often
  function automatic lfr_pkg::lfr_in_t rand_beat(input int unpin_pct, input bit narrow);
    lfr_pkg::lfr_in_t b;
    int               r;
    r = $urandom_range(99);
    if (r < 4)
      b.func = FUNC_NONE;
    else if (r < 4 + unpin_pct)
      b.func = lfr_pkg::FUNC_UNPIN;
    else if ($urandom_range(1))
      b.func = lfr_pkg::FUNC_PIN;
    else
      b.func = lfr_pkg::FUNC_VICTIM;
    if (narrow)
      b.frame = ($urandom_range(1) ? 6'd56 : 6'd0) + 6'($urandom_range(7));
    else
      b.frame = 6'($urandom_range(63));
    return b;
  endfunction

  initial begin
    lfr_pkg::lfr_in_t          at_reset[15];
    lfr_pkg::lfr_in_t          at_zero[2];
    lfr_pkg::lfr_in_t          at_one[4];
    logic [lfr_pkg::CAP_W-1:0] cap_plan[N_PHASES];

    // empty list, middle removal, repeated unpin and the unused code
    at_reset = '{
      '{lfr_pkg::FUNC_VICTIM, 6'd63}, '{lfr_pkg::FUNC_PIN, 6'd5}, '{FUNC_NONE, 6'd42},
      '{lfr_pkg::FUNC_UNPIN, 6'd0}, '{lfr_pkg::FUNC_UNPIN, 6'd63},
      '{lfr_pkg::FUNC_UNPIN, 6'd21}, '{lfr_pkg::FUNC_UNPIN, 6'd42},
      '{lfr_pkg::FUNC_UNPIN, 6'd63}, '{lfr_pkg::FUNC_PIN, 6'd21},
      '{lfr_pkg::FUNC_PIN, 6'd21}, '{lfr_pkg::FUNC_VICTIM, 6'd0},
      '{lfr_pkg::FUNC_VICTIM, 6'd0}, '{lfr_pkg::FUNC_VICTIM, 6'd0},
      '{lfr_pkg::FUNC_VICTIM, 6'd0}, '{FUNC_NONE, 6'd0}
    };
    // zero capacity: insert then drop at once
    at_zero = '{'{lfr_pkg::FUNC_UNPIN, 6'd7}, '{lfr_pkg::FUNC_VICTIM, 6'd0}};
    // capacity one: second unpin pushes out the first
    at_one = '{'{lfr_pkg::FUNC_UNPIN, 6'd1}, '{lfr_pkg::FUNC_UNPIN, 6'd2},
               '{lfr_pkg::FUNC_PIN, 6'd1}, '{lfr_pkg::FUNC_VICTIM, 6'd0}};
    // the first phase fills the list, the second cuts capacity below the count
    cap_plan = '{7'd127, 7'd5, 7'd0, 7'd64, 7'd1, 7'd16, 7'd63, 7'd3};

    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    out_stall    = 1'b0;
    cfg_valid    = 1'b0;
    cfg_capacity = '0;
    set_idling(0);

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed requests
    foreach (at_reset[i]) send_beat(at_reset[i]);
    wait_idle();
    write_capacity(7'd0);
    foreach (at_zero[i]) send_beat(at_zero[i]);
    wait_idle();
    write_capacity(7'd1);
    foreach (at_one[i]) send_beat(at_one[i]);
    wait_idle();

    // random phases, each with its own capacity and idling
    for (int p = 0; p < N_PHASES; p++) begin
      write_capacity(cap_plan[p]);
      set_idling(p % 4);
      for (int i = 0; i < PHASE_ITEMS; i++)
        send_beat(rand_beat(p == 0 ? 75 : 45, (p % 2 == 1) && ($urandom_range(3) != 0)));
      wait_idle();
    end

    repeat (10) @(negedge clk);
    if (errors == 0 && pending == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
